/* rtl/slc_pkg.sv */
// Package for the sorted list engine: field widths, operation and status
// codes, and the structs that pass between the top level and the cells.
// No dependencies.
package slc_pkg;

    localparam int VAL_W        = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int POS_W        = 4;
    localparam int CNT_W        = 5;
    localparam int CAPACITY_DEF = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // command broadcast to every cell
    typedef struct packed {
        logic                    ins_en;  // accepted insert into a non-full list
        logic                    rem_en;  // accepted remove of a present value
        logic signed [VAL_W-1:0] key;
    } slc_cmd_t;

    // what a cell shows its neighbors and the top level
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    valid;
        logic                    le;      // valid and value <= key
        logic                    eq;      // valid and value == key
    } slc_link_t;

endpackage

/* rtl/slc_if.sv */
// Handshake interfaces for the request and response channels.
// Depends on slc_pkg.
interface slc_req_if;
    logic                            valid;
    logic                            ready;
    logic [slc_pkg::OP_W-1:0]        op;
    logic signed [slc_pkg::VAL_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface slc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [slc_pkg::STATUS_W-1:0] status;
    logic [slc_pkg::POS_W-1:0]    position;
    logic [slc_pkg::CNT_W-1:0]    count;
    logic                         empty_res;

    modport source (output valid, output status, output position, output count,
                    output empty_res, input ready);
    modport sink   (input valid, input status, input position, input count,
                    input empty_res, output ready);
endinterface

/* rtl/sorted_list_engine_top.sv */
// Top level of the sorted list engine: a chain of compare-and-shift cells,
// the entry counter, the position encoder and the response register.
// Depends on slc_pkg, slc_if and slc_cell.
//
// Usage
//   req carries one operation per beat: op (insert, remove first equal,
//   find) and a signed 32-bit value. rsp returns exactly one beat per
//   request with status, position, count and empty_res.
//   Every cell compares its entry against the request value in the same
//   cycle and shifts toward its neighbor, so a request is finished in the
//   cycle it is accepted. The response is registered and valid in the cycle
//   after the request beat, and throughput is one request per cycle for any
//   CAPACITY while the receiver takes each response; the cycle time is set
//   by the key compare plus the found/position reduction across the chain.
//   req.ready is high while the response register is empty or being drained,
//   so a stalled receiver holds the response and blocks new requests.
//   Reset empties the list (all cell valid bits and the count clear) and
//   drops any pending response; no sweep is needed afterwards.
module sorted_list_engine_top #(
    parameter int CAPACITY = slc_pkg::CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    slc_req_if.sink   req,
    slc_rsp_if.source rsp
);
    import slc_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    slc_link_t              links [CAPACITY];
    logic [CAPACITY-1:0]    site_vec;
    logic [CAPACITY-1:0]    hit_vec;
    slc_cmd_t               cmd;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   accept;
    logic                   full;
    logic                   found;
    logic [IW-1:0]          site_idx;
    logic [IW-1:0]          hit_idx;

    logic                   rsp_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [STATUS_W-1:0]    status_next;
    logic [POS_W-1:0]       position_reg;
    logic [POS_W-1:0]       position_next;
    logic [IW-1:0]          pos_idx;
    logic [31:0]            pos_wide;
    logic [31:0]            cnt_wide;

    // handshake and broadcast command
    assign accept  = req.valid && req.ready;
    assign full    = (count_reg == CW'(CAPACITY));
    assign found   = |hit_vec;
    assign cmd.key    = req.value;
    assign cmd.ins_en = accept && (req.op == OP_INSERT) && !full;
    assign cmd.rem_en = accept && (req.op == OP_REMOVE) && found;

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        slc_link_t left_l;
        slc_link_t right_l;

        if (i == 0)
        begin : g_head
            assign left_l = '{value: '0, valid: 1'b1, le: 1'b1, eq: 1'b0};
        end
        else
        begin : g_left
            assign left_l = links[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_l = '{value: '0, valid: 1'b0, le: 1'b0, eq: 1'b0};
        end
        else
        begin : g_right
            assign right_l = links[i+1];
        end

        slc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_link  (left_l),
            .right_link (right_l),
            .link       (links[i]),
            .ins_site   (site_vec[i]),
            .first_hit  (hit_vec[i])
        );
    end

    // one-hot to index encoders
    always_comb
    begin
        site_idx = '0;
        hit_idx  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (site_vec[i])
            begin
                site_idx = site_idx | IW'(i);
            end
            if (hit_vec[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
        end
    end

    // result and next count
    always_comb
    begin
        status_next = ST_ABSENT;
        pos_idx     = '0;
        count_next  = count_reg;
        case (req.op)
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    pos_idx     = site_idx;
                    count_next  = count_reg + CW'(1);
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    status_next = ST_OK;
                    pos_idx     = hit_idx;
                    count_next  = count_reg - CW'(1);
                end
            end
            OP_FIND:
            begin
                if (found)
                begin
                    status_next = ST_OK;
                    pos_idx     = hit_idx;
                end
            end
            default:
            begin
                status_next = ST_ABSENT;
            end
        endcase
        pos_wide      = 32'(pos_idx);
        position_next = pos_wide[POS_W-1:0];
    end

    // entry counter and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
        end
    end

    assign req.ready     = !rsp_valid_reg || rsp.ready;
    assign cnt_wide      = 32'(count_reg);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.position  = position_reg;
    assign rsp.count     = cnt_wide[CNT_W-1:0];
    assign rsp.empty_res = (count_reg == '0);

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one first-equal cell");

    a_site_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(site_vec))
        else $error("more than one insert site");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_en |=> (count_reg == $past(count_reg) + CW'(1)) && rsp.valid
            && (rsp.status == ST_OK))
        else $error("insert did not grow the list");

endmodule

/* rtl/slc_cell.sv */
// One storage cell of the sorted list: holds one entry, compares it with the
// broadcast key and shifts in from its left or right neighbor.
// Depends on slc_pkg.
module slc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  slc_pkg::slc_cmd_t  cmd,
    input  slc_pkg::slc_link_t left_link,   // tie le high at the head
    input  slc_pkg::slc_link_t right_link,  // tie valid low at the tail
    output slc_pkg::slc_link_t link,
    output logic               ins_site,
    output logic               first_hit
);
    import slc_pkg::*;

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic                    valid_reg;
    logic                    valid_next;
    logic                    ge;

    // compares against the broadcast key
    always_comb
    begin
        link.value = value_reg;
        link.valid = valid_reg;
        link.le    = valid_reg && (value_reg <= cmd.key);
        link.eq    = valid_reg && (value_reg == cmd.key);
        ge         = valid_reg && !(value_reg < cmd.key);
        ins_site   = left_link.le && !link.le;
        first_hit  = link.eq && !left_link.eq;
    end

    // insert shifts right past the site, remove shifts left from the hit
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (cmd.ins_en)
        begin
            if (!left_link.le)
            begin
                value_next = left_link.value;
                valid_next = left_link.valid;
            end
            else if (!link.le)
            begin
                value_next = cmd.key;
                valid_next = 1'b1;
            end
        end
        else if (cmd.rem_en && ge)
        begin
            value_next = right_link.value;
            valid_next = right_link.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
